FILE: hdl/poisson_disk_grid_accept_core_assert.svh
// Assertion macros for the Poisson disk grid acceptance core.
`ifndef POISSON_DISK_GRID_ACCEPT_CORE_ASSERT_SVH
`define POISSON_DISK_GRID_ACCEPT_CORE_ASSERT_SVH

// same-cycle implication, needs clk and rst_n in scope
`define PDGA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pdga_pkg.sv
// Shared types and constants for the Poisson disk grid acceptance core.
package pdga_pkg;

  localparam int GRID_SIDE_DEF   = 64;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int COORD_BITS_DEF  = 16;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int SIDE_CFG_W = 7;
  localparam int OUT_IDX_W  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST_SQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE   = 1'd1;

  localparam logic OP_TEST  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [CFG_DATA_W-1:0] MIN_DIST_SQ_RST = 32'd2097152;
  localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RST   = 7'd64;

  localparam int               WIN_W      = 3;
  localparam logic [WIN_W-1:0] WIN_LAST   = 3'd4;
  localparam logic [WIN_W-1:0] WIN_REACH  = 3'd2;

  // cycles between the last window read and the reject flag being final
  localparam int                 DRAIN_W    = 2;
  localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             map;
    logic             scan;
    logic [WIN_W-1:0] win_r;
    logic [WIN_W-1:0] win_c;
    logic             clr_step;
    logic             finish;
    logic             clr_op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/pdga_ctrl.sv
// Sequencer: grid sweep, window walk, drain and result handoff.
module pdga_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_op,
  output logic             in_ready,
  input  pdga_pkg::stat_t  stat,
  output pdga_pkg::cmd_t   cmd
);

  pdga_pkg::state_t                  state_r, state_nxt;
  logic [pdga_pkg::WIN_W-1:0]        wr_r, wr_nxt;
  logic [pdga_pkg::WIN_W-1:0]        wc_r, wc_nxt;
  logic [pdga_pkg::DRAIN_W-1:0]      dr_r, dr_nxt;
  logic                              pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdga_pkg::S_CLEAR;
      wr_r    <= '0;
      wc_r    <= '0;
      dr_r    <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wr_r    <= wr_nxt;
      wc_r    <= wc_nxt;
      dr_r    <= dr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    wc_nxt    = wc_r;
    dr_nxt    = dr_r;
    pend_nxt  = pend_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.win_r = wr_r;
    cmd.win_c = wc_r;
    case (state_r)
      pdga_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          state_nxt = pend_r ? pdga_pkg::S_FINISH : pdga_pkg::S_IDLE;
        end
      end
      pdga_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == pdga_pkg::OP_CLEAR) begin
            pend_nxt  = 1'b1;
            state_nxt = pdga_pkg::S_CLEAR;
          end else begin
            state_nxt = pdga_pkg::S_MAP;
          end
        end
      end
      pdga_pkg::S_MAP: begin
        cmd.map   = 1'b1;
        wr_nxt    = '0;
        wc_nxt    = '0;
        state_nxt = pdga_pkg::S_SCAN;
      end
      pdga_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (wc_r == pdga_pkg::WIN_LAST) begin
          wc_nxt = '0;
          if (wr_r == pdga_pkg::WIN_LAST) begin
            dr_nxt    = '0;
            state_nxt = pdga_pkg::S_DRAIN;
          end else begin
            wr_nxt = wr_r + 1'b1;
          end
        end else begin
          wc_nxt = wc_r + 1'b1;
        end
      end
      pdga_pkg::S_DRAIN: begin
        if (dr_r == pdga_pkg::DRAIN_LAST) begin
          state_nxt = pdga_pkg::S_FINISH;
        end else begin
          dr_nxt = dr_r + 1'b1;
        end
      end
      pdga_pkg::S_FINISH: begin
        cmd.clr_op = pend_r;
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          pend_nxt   = 1'b0;
          state_nxt  = pdga_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pdga_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/pdga_dpath.sv
// Datapath: config registers, cell and sample memories, distance pipeline, result register.
`include "poisson_disk_grid_accept_core_assert.svh"

module pdga_dpath #(
  parameter int GRID_SIDE   = pdga_pkg::GRID_SIDE_DEF,
  parameter int MAX_SAMPLES = pdga_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_BITS  = pdga_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pdga_pkg::cmd_t                    cmd,
  output pdga_pkg::stat_t                   stat,
  input  logic [COORD_BITS-1:0]             in_point_x,
  input  logic [COORD_BITS-1:0]             in_point_y,
  input  logic                              cfg_we,
  input  logic [pdga_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdga_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic [pdga_pkg::OUT_IDX_W-1:0]    out_sample_index,
  output logic                              out_store_full
);

  localparam int SIDE_W  = $clog2(GRID_SIDE);
  localparam int SIDEN_W = $clog2(GRID_SIDE + 1);
  localparam int CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int CELL_AW = $clog2(CELLS);
  localparam int IDX_W   = $clog2(MAX_SAMPLES);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int PW      = COORD_BITS + SIDEN_W;
  localparam int WW      = SIDE_W + 2;
  localparam int SQ_W    = 2 * COORD_BITS;
  localparam int DSQ_W   = SQ_W + 1;
  localparam int CMP_W   = SQ_W + 34;
  localparam int SH_L    = (SQ_W < 32) ? (32 - SQ_W) : 0;
  localparam int SH_R    = (SQ_W >= 32) ? (SQ_W - 32) : 0;
  localparam int OIW     = pdga_pkg::OUT_IDX_W;

  // configuration
  logic [pdga_pkg::CFG_DATA_W-1:0] min_dist_sq_r;
  logic [pdga_pkg::SIDE_CFG_W-1:0] grid_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_sq_r <= pdga_pkg::MIN_DIST_SQ_RST;
      grid_side_r   <= pdga_pkg::GRID_SIDE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pdga_pkg::CFG_MIN_DIST_SQ: min_dist_sq_r <= cfg_data;
        pdga_pkg::CFG_GRID_SIDE:   grid_side_r   <= cfg_data[pdga_pkg::SIDE_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIDEN_W-1:0] side_use;

  always_comb begin
    if (grid_side_r == '0) begin
      side_use = SIDEN_W'(1);
    end else if (int'(grid_side_r) > GRID_SIDE) begin
      side_use = SIDEN_W'(GRID_SIDE);
    end else begin
      side_use = SIDEN_W'(grid_side_r);
    end
  end

  // request capture
  logic [COORD_BITS-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= in_point_x;
      py_r <= in_point_y;
    end
  end

  // home cell
  logic [PW-1:0]      prod_x, prod_y;
  logic [SIDEN_W-1:0] cx_raw, cy_raw, cx_cl, cy_cl;
  logic [SIDE_W-1:0]  row_r, col_r;

  assign prod_x = PW'(px_r) * PW'(side_use);
  assign prod_y = PW'(py_r) * PW'(side_use);
  assign cx_raw = prod_x[COORD_BITS +: SIDEN_W];
  assign cy_raw = prod_y[COORD_BITS +: SIDEN_W];
  assign cx_cl  = (cx_raw >= side_use) ? side_use - 1'b1 : cx_raw;
  assign cy_cl  = (cy_raw >= side_use) ? side_use - 1'b1 : cy_raw;

  always_ff @(posedge clk) begin
    if (cmd.map) begin
      row_r <= SIDE_W'(cx_cl);
      col_r <= SIDE_W'(cy_cl);
    end
  end

  // window cell address
  logic [WW-1:0]      rr, cc, r_act, c_act;
  logic               in_win;
  logic [CELL_AW-1:0] scan_addr, home_addr;

  assign rr     = WW'(row_r) + WW'(cmd.win_r);
  assign cc     = WW'(col_r) + WW'(cmd.win_c);
  assign r_act  = rr - WW'(pdga_pkg::WIN_REACH);
  assign c_act  = cc - WW'(pdga_pkg::WIN_REACH);
  assign in_win = (rr >= WW'(pdga_pkg::WIN_REACH)) && (cc >= WW'(pdga_pkg::WIN_REACH)) &&
                  (r_act < WW'(side_use)) && (c_act < WW'(side_use));
  assign scan_addr = CELL_AW'(r_act[SIDE_W-1:0]) * CELL_AW'(GRID_SIDE) +
                     CELL_AW'(c_act[SIDE_W-1:0]);
  assign home_addr = CELL_AW'(row_r) * CELL_AW'(GRID_SIDE) + CELL_AW'(col_r);

  // sample count and clear sweep
  logic [CNT_W-1:0]   count_r;
  logic [CELL_AW-1:0] clr_addr_r;
  logic               reject_r;
  logic               acc_now, full_now;

  assign acc_now  = !cmd.clr_op && !reject_r && (count_r < CNT_W'(MAX_SAMPLES));
  assign full_now = !cmd.clr_op && !reject_r && (count_r >= CNT_W'(MAX_SAMPLES));
  assign stat.clr_done = (clr_addr_r == CELL_AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= stat.clr_done ? '0 : clr_addr_r + 1'b1;
      end
      if (cmd.finish && cmd.clr_op) begin
        count_r <= '0;
      end else if (cmd.finish && acc_now) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // cell memory: valid bit over sample index
  logic [IDX_W:0]       cell_mem_r [CELLS];
  logic [IDX_W:0]       cell_rd_r;
  logic                 cell_we;
  logic [CELL_AW-1:0]   cell_wa;
  logic [IDX_W:0]       cell_wd;

  assign cell_we = cmd.clr_step || (cmd.finish && acc_now);
  assign cell_wa = cmd.clr_step ? clr_addr_r : home_addr;
  assign cell_wd = cmd.clr_step ? '0 : {1'b1, count_r[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem_r[cell_wa] <= cell_wd;
    end
    cell_rd_r <= cell_mem_r[scan_addr];
  end

  // sample memory: x over y
  logic [SQ_W-1:0] samp_mem_r [MAX_SAMPLES];
  logic [SQ_W-1:0] samp_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.finish && acc_now) begin
      samp_mem_r[count_r[IDX_W-1:0]] <= {px_r, py_r};
    end
    samp_rd_r <= samp_mem_r[cell_rd_r[IDX_W-1:0]];
  end

  // distance pipeline
  logic                  a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  logic                  hit;
  logic [COORD_BITS-1:0] sx, sy, dx_r, dy_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic [DSQ_W-1:0]      dsq;
  logic [CMP_W-1:0]      lhs, rhs;

  assign hit = a_vld_r && cell_rd_r[IDX_W] && (CNT_W'(cell_rd_r[IDX_W-1:0]) < count_r);
  assign sx  = samp_rd_r[SQ_W-1:COORD_BITS];
  assign sy  = samp_rd_r[COORD_BITS-1:0];
  assign dsq = DSQ_W'(sqx_r) + DSQ_W'(sqy_r);
  assign lhs = CMP_W'(dsq) << SH_L;
  assign rhs = CMP_W'(min_dist_sq_r) << SH_R;

  always_ff @(posedge clk) begin
    dx_r  <= (px_r >= sx) ? px_r - sx : sx - px_r;
    dy_r  <= (py_r >= sy) ? py_r - sy : sy - py_r;
    sqx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r  <= 1'b0;
      b_vld_r  <= 1'b0;
      c_vld_r  <= 1'b0;
      d_vld_r  <= 1'b0;
      reject_r <= 1'b0;
    end else begin
      a_vld_r <= cmd.scan && in_win;
      b_vld_r <= hit;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      if (cmd.map) begin
        reject_r <= 1'b0;
      end else if (d_vld_r && (lhs < rhs)) begin
        reject_r <= 1'b1;
      end
    end
  end

  // result register
  logic                         out_valid_r, out_acc_r, out_full_r;
  logic [OIW-1:0]               out_idx_r;
  logic [IDX_W+OIW-1:0]         idx_ext;

  assign idx_ext       = (IDX_W + OIW)'(count_r[IDX_W-1:0]);
  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_acc_r  <= acc_now;
      out_idx_r  <= acc_now ? idx_ext[OIW-1:0] : '0;
      out_full_r <= full_now;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_sample_index = out_idx_r;
  assign out_store_full   = out_full_r;

  `PDGA_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_SAMPLES), "sample count overflow")
  `PDGA_ASSERT_SAME(a_finish_free, cmd.finish, stat.out_free, "result dropped on busy output")
  `PDGA_ASSERT_NEXT(a_accept_inc, cmd.finish && acc_now,
                    count_r == $past(count_r) + CNT_W'(1), "count not advanced on insert")
  `PDGA_ASSERT_NEXT(a_clear_zero, cmd.finish && cmd.clr_op, count_r == '0, "count not cleared")

endmodule

FILE: hdl/poisson_disk_grid_accept_core.sv
// Top level of the Poisson disk grid acceptance core.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_operation, in_point_x, in_point_y
//   out     | output    | out_valid/out_ready| out_accepted, out_sample_index, out_store_full
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Test request: after accept the core maps the home cell, reads the 5x5 window of cells
// one cell at a time from the cell memory, drains the distance pipeline, then finishes.
// Clear request: sweeps all GRID_SIDE*GRID_SIDE cells of the cell memory, then finishes.
// After reset the same sweep runs with in_ready low.
// A waiting result does not block the next request; finish stalls until out is free.
module poisson_disk_grid_accept_core #(
  parameter int GRID_SIDE   = pdga_pkg::GRID_SIDE_DEF,
  parameter int MAX_SAMPLES = pdga_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_BITS  = pdga_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [COORD_BITS-1:0]             in_point_x,
  input  logic [COORD_BITS-1:0]             in_point_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accepted,
  output logic [pdga_pkg::OUT_IDX_W-1:0]    out_sample_index,
  output logic                              out_store_full,
  input  logic                              cfg_we,
  input  logic [pdga_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdga_pkg::CFG_DATA_W-1:0]   cfg_data
);

  pdga_pkg::cmd_t  cmd;
  pdga_pkg::stat_t stat;

  pdga_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_operation),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pdga_dpath #(
    .GRID_SIDE   (GRID_SIDE),
    .MAX_SAMPLES (MAX_SAMPLES),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_accepted     (out_accepted),
    .out_sample_index (out_sample_index),
    .out_store_full   (out_store_full)
  );

endmodule
